/* sv/wsdf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package wsdf_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXT     = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CLOSED  = 3'd5
    } t_phase;

    localparam logic [1:0]  KIND_PAYLOAD    = 2'd0;
    localparam logic [1:0]  KIND_EMPTY      = 2'd1;
    localparam logic [1:0]  KIND_ERROR      = 2'd2;
    localparam logic [1:0]  KIND_NONE       = 2'd3;

    localparam logic [3:0]  OP_CONTINUE     = 4'h0;
    localparam logic [3:0]  OP_CLOSE        = 4'h8;
    localparam logic [15:0] STATUS_PROTOCOL = 16'd1002;
    localparam logic [6:0]  LEN_EXT16       = 7'd126;
    localparam logic [6:0]  LEN_EXT64       = 7'd127;
    localparam logic [3:0]  EXT_BYTES16     = 4'd2;
    localparam logic [3:0]  EXT_BYTES64     = 4'd8;
    localparam logic [2:0]  MASK_BYTES      = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic        frame_fin;
        logic [3:0]  frame_opcode;
        logic [3:0]  message_opcode;
        logic [63:0] message_length;
        logic        is_close;
        logic [15:0] close_status;
    } t_result;

endpackage
`default_nettype wire

/* sv/websocket_frame_deframer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Client-to-server WebSocket deframer. One received byte is taken per word on the
// input channel, every cycle while the queue has room; each byte is parsed and,
// for payload, unmasked in the cycle it is accepted, and any result is registered
// into a two-word output queue, so input keeps flowing while one result waits
// downstream. Input stalls only when both queue slots are full. Sustained rate:
// one byte per cycle while the queue has room, set by the header/length/mask
// parser and the length countdown, which each handle a byte as it is accepted.
// An unmasked frame or the end of a close frame leaves the block closed: later
// bytes are taken and dropped until reset. Lengths saturate at 2^LENGTH_BITS-1.
module websocket_frame_deframer #(
    parameter int LENGTH_BITS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_frame_last,
    output logic        o_frame_fin,
    output logic [3:0]  o_frame_opcode,
    output logic [3:0]  o_message_opcode,
    output logic [63:0] o_message_length,
    output logic        o_is_close,
    output logic [15:0] o_close_status
);

    wsdf_pkg::t_phase         r_phase, n_phase;
    logic [7:0]               r_hdr, n_hdr;
    logic [3:0]               r_ext, n_ext;
    logic [LENGTH_BITS-1:0]   r_rem, n_rem;
    logic                     r_ovf, n_ovf;
    logic [1:0]               r_pos, n_pos;
    logic [1:0]               r_cnt, n_cnt;
    logic [31:0]              r_key, n_key;
    logic [2:0]               r_mskl, n_mskl;
    logic                     r_frag, n_frag;
    logic [3:0]               r_ffo, n_ffo;
    logic [LENGTH_BITS-1:0]   r_total, n_total;
    logic [15:0]              r_cc, n_cc;

    wsdf_pkg::t_result        r_q [2];
    logic                     r_wp, r_rp;
    logic [1:0]               r_qn;

    wsdf_pkg::t_result        res;
    logic                     res_vld;
    logic                     acc, push, pop;
    logic [7:0]               key_b, v;
    logic [LENGTH_BITS:0]     sum;
    logic                     closing;
    logic [3:0]               op;

    assign acc  = i_in_valid && o_in_ready;
    assign push = acc && res_vld;
    assign pop  = o_out_valid && i_out_ready;
    assign op   = r_hdr[3:0];

    always_comb begin
        case (r_pos)
            2'd0:    key_b = r_key[31:24];
            2'd1:    key_b = r_key[23:16];
            2'd2:    key_b = r_key[15:8];
            default: key_b = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_ext   = r_ext;
        n_rem   = r_rem;
        n_ovf   = r_ovf;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_key   = r_key;
        n_mskl  = r_mskl;
        n_frag  = r_frag;
        n_ffo   = r_ffo;
        n_total = r_total;
        n_cc    = r_cc;
        res_vld = 1'b0;
        closing = 1'b0;
        v       = i_rx_byte ^ key_b;
        sum     = {1'b0, r_total} + {1'b0, r_rem};
        res.kind         = wsdf_pkg::KIND_NONE;
        res.payload_byte = 8'd0;
        res.frame_last   = 1'b0;
        res.is_close     = 1'b0;
        res.close_status = 16'd0;
        case (r_phase)
            wsdf_pkg::PH_HEADER: begin
                n_hdr   = i_rx_byte;
                n_phase = wsdf_pkg::PH_LEN;
            end
            wsdf_pkg::PH_LEN: begin
                if (!i_rx_byte[7]) begin
                    n_ffo            = 4'd0;
                    n_total          = '0;
                    res_vld          = 1'b1;
                    res.kind         = wsdf_pkg::KIND_ERROR;
                    res.frame_last   = 1'b1;
                    res.close_status = wsdf_pkg::STATUS_PROTOCOL;
                    n_phase          = wsdf_pkg::PH_CLOSED;
                end else begin
                    n_rem = '0;
                    n_ovf = 1'b0;
                    if (i_rx_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
                        n_ext   = wsdf_pkg::EXT_BYTES16;
                        n_phase = wsdf_pkg::PH_EXT;
                    end else if (i_rx_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
                        n_ext   = wsdf_pkg::EXT_BYTES64;
                        n_phase = wsdf_pkg::PH_EXT;
                    end else begin
                        n_rem   = LENGTH_BITS'(i_rx_byte[6:0]);
                        n_mskl  = wsdf_pkg::MASK_BYTES;
                        n_phase = wsdf_pkg::PH_MASK;
                    end
                end
            end
            wsdf_pkg::PH_EXT: begin
                n_ovf = r_ovf || (|r_rem[LENGTH_BITS-1:LENGTH_BITS-8]);
                n_rem = {r_rem[LENGTH_BITS-9:0], i_rx_byte};
                n_ext = r_ext - 4'd1;
                if (r_ext == 4'd1) begin
                    if (n_ovf) begin
                        n_rem = '1;
                    end
                    n_mskl  = wsdf_pkg::MASK_BYTES;
                    n_phase = wsdf_pkg::PH_MASK;
                end
            end
            wsdf_pkg::PH_MASK: begin
                n_key  = {r_key[23:0], i_rx_byte};
                n_mskl = r_mskl - 3'd1;
                if (r_mskl == 3'd1) begin
                    if (!r_hdr[7] || op == wsdf_pkg::OP_CONTINUE) begin
                        if (!r_frag) begin
                            n_frag  = 1'b1;
                            n_ffo   = op;
                            n_total = r_rem;
                        end else if (sum[LENGTH_BITS]) begin
                            n_total = '1;
                        end else begin
                            n_total = sum[LENGTH_BITS-1:0];
                        end
                    end else begin
                        n_ffo   = op;
                        n_total = r_rem;
                    end
                    n_pos = 2'd0;
                    n_cnt = 2'd0;
                    n_cc  = 16'd0;
                    if (r_rem == '0) begin
                        closing = (op == wsdf_pkg::OP_CLOSE);
                        if (closing) begin
                            n_phase = wsdf_pkg::PH_CLOSED;
                        end else begin
                            if (r_hdr[7]) begin
                                n_frag = 1'b0;
                            end
                            n_phase = wsdf_pkg::PH_HEADER;
                        end
                        res_vld        = 1'b1;
                        res.kind       = wsdf_pkg::KIND_EMPTY;
                        res.frame_last = 1'b1;
                        res.is_close   = closing;
                    end else begin
                        n_phase = wsdf_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsdf_pkg::PH_PAYLOAD: begin
                if (op == wsdf_pkg::OP_CLOSE) begin
                    if (r_cnt == 2'd0) begin
                        n_cc = {v, 8'd0};
                    end else if (r_cnt == 2'd1) begin
                        n_cc = {r_cc[15:8], v};
                    end
                end
                n_pos = r_pos + 2'd1;
                if (r_cnt != 2'd2) begin
                    n_cnt = r_cnt + 2'd1;
                end
                n_rem            = r_rem - LENGTH_BITS'(1);
                res_vld          = 1'b1;
                res.kind         = wsdf_pkg::KIND_PAYLOAD;
                res.payload_byte = v;
                if (r_rem == LENGTH_BITS'(1)) begin
                    closing = (op == wsdf_pkg::OP_CLOSE);
                    if (closing) begin
                        n_phase = wsdf_pkg::PH_CLOSED;
                        if (n_cnt == 2'd2) begin
                            res.close_status = n_cc;
                        end
                    end else begin
                        if (r_hdr[7]) begin
                            n_frag = 1'b0;
                        end
                        n_phase = wsdf_pkg::PH_HEADER;
                    end
                    res.frame_last = 1'b1;
                    res.is_close   = closing;
                end
            end
            default: begin
                n_phase = wsdf_pkg::PH_CLOSED;
            end
        endcase
        res.frame_fin      = n_hdr[7];
        res.frame_opcode   = n_hdr[3:0];
        res.message_opcode = n_ffo;
        res.message_length = 64'(n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wsdf_pkg::PH_HEADER;
            r_hdr   <= 8'd0;
            r_ext   <= 4'd0;
            r_rem   <= '0;
            r_ovf   <= 1'b0;
            r_pos   <= 2'd0;
            r_cnt   <= 2'd0;
            r_key   <= 32'd0;
            r_mskl  <= 3'd0;
            r_frag  <= 1'b0;
            r_ffo   <= 4'd0;
            r_total <= '0;
            r_cc    <= 16'd0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_ext   <= n_ext;
            r_rem   <= n_rem;
            r_ovf   <= n_ovf;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_key   <= n_key;
            r_mskl  <= n_mskl;
            r_frag  <= n_frag;
            r_ffo   <= n_ffo;
            r_total <= n_total;
            r_cc    <= n_cc;
        end
    end

    // two-word result queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_qn <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_qn <= r_qn + 2'd1;
                2'b01:   r_qn <= r_qn - 2'd1;
                default: r_qn <= r_qn;
            endcase
        end
    end

    assign o_in_ready       = (r_qn != 2'd2);
    assign o_out_valid      = (r_qn != 2'd0);
    assign o_result_kind    = r_q[r_rp].kind;
    assign o_payload_byte   = r_q[r_rp].payload_byte;
    assign o_frame_last     = r_q[r_rp].frame_last;
    assign o_frame_fin      = r_q[r_rp].frame_fin;
    assign o_frame_opcode   = r_q[r_rp].frame_opcode;
    assign o_message_opcode = r_q[r_rp].message_opcode;
    assign o_message_length = r_q[r_rp].message_length;
    assign o_is_close       = r_q[r_rp].is_close;
    assign o_close_status   = r_q[r_rp].close_status;

endmodule
`default_nettype wire

/* sv/wsdf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module wsdf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [1:0]  o_result_kind,
    input wire [7:0]  o_payload_byte,
    input wire        o_frame_last,
    input wire        o_frame_fin,
    input wire [3:0]  o_frame_opcode,
    input wire [3:0]  o_message_opcode,
    input wire [63:0] o_message_length,
    input wire        o_is_close,
    input wire [15:0] o_close_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_kind) && $stable(o_payload_byte)
            && $stable(o_frame_fin) && $stable(o_message_opcode)
            && $stable(o_message_length) && $stable(o_close_status))
        else $error("result word changed while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_result_kind != wsdf_pkg::KIND_NONE)
        else $error("illegal result kind");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == wsdf_pkg::KIND_ERROR |->
            o_frame_last && !o_is_close
            && o_close_status == wsdf_pkg::STATUS_PROTOCOL
            && o_message_length == 64'd0)
        else $error("malformed unmasked-frame error word");

    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_close |->
            o_frame_last && o_frame_opcode == wsdf_pkg::OP_CLOSE)
        else $error("close flagged on a word that does not end a close frame");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == wsdf_pkg::KIND_EMPTY |->
            o_frame_last && o_payload_byte == 8'd0 && o_close_status == 16'd0)
        else $error("malformed empty-frame word");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (.*);
`default_nettype wire

/* test/deframer_checker.sv */
`timescale 1ns / 1ps
module deframer_checker
    import wsdf_pkg::*;
#(
    parameter int LENGTH_BITS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [7:0]  i_rx_byte,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [1:0]  i_result_kind,
    input  wire  [7:0]  i_payload_byte,
    input  wire         i_frame_last,
    input  wire         i_frame_fin,
    input  wire  [3:0]  i_frame_opcode,
    input  wire  [3:0]  i_message_opcode,
    input  wire  [63:0] i_message_length,
    input  wire         i_is_close,
    input  wire  [15:0] i_close_status,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

    t_phase      phase;
    logic [7:0]  hdr;
    logic [3:0]  ext_left;
    logic [63:0] bytes_left;
    logic [63:0] byte_index;
    logic [31:0] mask_word;
    logic [2:0]  mask_left;
    logic        in_message;
    logic [3:0]  msg_opcode;
    logic [63:0] msg_length;
    logic [15:0] status_word;
    logic        link_down;

    t_result     expected_words[$];
    t_result     want;
    int          fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_result make_result(input logic [1:0] kind, input logic [7:0] data,
                                            input logic last, input logic closing,
                                            input logic [15:0] status);
        t_result r;
        r.kind           = kind;
        r.payload_byte   = data;
        r.frame_last     = last;
        r.frame_fin      = hdr[7];
        r.frame_opcode   = hdr[3:0];
        r.message_opcode = msg_opcode;
        r.message_length = msg_length;
        r.is_close       = closing;
        r.close_status   = status;
        return r;
    endfunction

    task automatic open_frame();
        if (!hdr[7] || hdr[3:0] == OP_CONTINUE) begin
            if (!in_message) begin
                in_message = 1'b1;
                msg_opcode = hdr[3:0];
                msg_length = bytes_left;
            end else if (LEN_MAX - msg_length < bytes_left) begin
                msg_length = LEN_MAX;
            end else begin
                msg_length = msg_length + bytes_left;
            end
        end else begin
            msg_opcode = hdr[3:0];
            msg_length = bytes_left;
        end
        byte_index  = '0;
        status_word = '0;
    endtask

    task automatic finish_frame(output logic closing, output logic [15:0] status);
        closing = (hdr[3:0] == OP_CLOSE);
        status  = '0;
        if (closing) begin
            if (byte_index >= 2)
                status = status_word;
            link_down = 1'b1;
            phase     = PH_CLOSED;
        end else begin
            if (hdr[7])
                in_message = 1'b0;
            phase = PH_HEADER;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic        closing;
        logic [15:0] status;
        logic [7:0]  v;
        int          lane;
        if (link_down || phase == PH_CLOSED)
            return;
        case (phase)
            PH_HEADER: begin
                hdr   = b;
                phase = PH_LEN;
            end
            PH_LEN: begin
                if (!b[7]) begin
                    msg_opcode = '0;
                    msg_length = '0;
                    expected_words.push_back(make_result(KIND_ERROR, 8'h00, 1'b1, 1'b0,
                                                         STATUS_PROTOCOL));
                    link_down = 1'b1;
                    phase     = PH_CLOSED;
                end else begin
                    bytes_left = '0;
                    if (b[6:0] == LEN_EXT16) begin
                        ext_left = EXT_BYTES16;
                        phase    = PH_EXT;
                    end else if (b[6:0] == LEN_EXT64) begin
                        ext_left = EXT_BYTES64;
                        phase    = PH_EXT;
                    end else begin
                        bytes_left = {57'd0, b[6:0]};
                        mask_left  = MASK_BYTES;
                        phase      = PH_MASK;
                    end
                end
            end
            PH_EXT: begin
                bytes_left = {bytes_left[55:0], b};
                ext_left   = ext_left - 4'd1;
                if (ext_left == 0) begin
                    if (bytes_left > LEN_MAX)
                        bytes_left = LEN_MAX;
                    mask_left = MASK_BYTES;
                    phase     = PH_MASK;
                end
            end
            PH_MASK: begin
                mask_word = {mask_word[23:0], b};
                mask_left = mask_left - 3'd1;
                if (mask_left == 0) begin
                    open_frame();
                    if (bytes_left == 0) begin
                        finish_frame(closing, status);
                        expected_words.push_back(make_result(KIND_EMPTY, 8'h00, 1'b1,
                                                             closing, status));
                    end else begin
                        phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                lane = 3 - int'(byte_index[1:0]);
                v    = b ^ mask_word[8*lane +: 8];
                if (hdr[3:0] == OP_CLOSE) begin
                    if (byte_index == 0)
                        status_word = {v, 8'h00};
                    else if (byte_index == 1)
                        status_word[7:0] = v;
                end
                byte_index = byte_index + 64'd1;
                bytes_left = bytes_left - 64'd1;
                if (bytes_left == 0) begin
                    finish_frame(closing, status);
                    expected_words.push_back(make_result(KIND_PAYLOAD, v, 1'b1, closing,
                                                         status));
                end else begin
                    expected_words.push_back(make_result(KIND_PAYLOAD, v, 1'b0, 1'b0,
                                                         16'd0));
                end
            end
            default: begin
                phase     = PH_CLOSED;
                link_down = 1'b1;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase       = PH_HEADER;
            hdr         = '0;
            ext_left    = '0;
            bytes_left  = '0;
            byte_index  = '0;
            mask_word   = '0;
            mask_left   = '0;
            in_message  = 1'b0;
            msg_opcode  = '0;
            msg_length  = '0;
            status_word = '0;
            link_down   = 1'b0;
            expected_words.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                deframe_byte(i_rx_byte);
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word, kind %0d", i_result_kind);
                    fails++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("result_kind", want.kind, i_result_kind);
                    check_field("payload_byte", want.payload_byte, i_payload_byte);
                    check_field("frame_last", want.frame_last, i_frame_last);
                    check_field("frame_fin", want.frame_fin, i_frame_fin);
                    check_field("frame_opcode", want.frame_opcode, i_frame_opcode);
                    check_field("message_opcode", want.message_opcode, i_message_opcode);
                    check_field("message_length", want.message_length, i_message_length);
                    check_field("is_close", want.is_close, i_is_close);
                    check_field("close_status", want.close_status, i_close_status);
                end
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fails;
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import wsdf_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BYTES = 1950;

    localparam int FORM_SHORT = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    typedef enum int {
        END_CLOSE,
        END_CLOSE_SHORT,
        END_CLOSE_FRAG,
        END_UNMASKED,
        END_HUGE
    } t_ending;

    logic        i_clk     = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_ready = 1'b0;
    logic        gaps_on   = 1'b1;

    wire         in_ready;
    wire         out_valid;
    wire  [1:0]  result_kind;
    wire  [7:0]  payload_byte;
    wire         frame_last;
    wire         frame_fin;
    wire  [3:0]  frame_opcode;
    wire  [3:0]  message_opcode;
    wire  [63:0] message_length;
    wire         is_close;
    wire  [15:0] close_status;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          sent_bytes  = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    websocket_frame_deframer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_result_kind    (result_kind),
        .o_payload_byte   (payload_byte),
        .o_frame_last     (frame_last),
        .o_frame_fin      (frame_fin),
        .o_frame_opcode   (frame_opcode),
        .o_message_opcode (message_opcode),
        .o_message_length (message_length),
        .o_is_close       (is_close),
        .o_close_status   (close_status)
    );

    deframer_checker i_deframe_check (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_result_kind    (result_kind),
        .i_payload_byte   (payload_byte),
        .i_frame_last     (frame_last),
        .i_frame_fin      (frame_fin),
        .i_frame_opcode   (frame_opcode),
        .i_message_opcode (message_opcode),
        .i_message_length (message_length),
        .i_is_close       (is_close),
        .i_close_status   (close_status),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        if (gaps_on)
            out_ready <= ($urandom_range(99, 0) >= 26);
        else
            out_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (gaps_on && $urandom_range(99, 0) < 26) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge i_clk);
        while (!in_ready);
        sent_bytes++;
    endtask

    task automatic send_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                               input logic [63:0] len, input int form,
                               input logic [31:0] key);
        int i;
        send_byte({fin, rsv, op});
        case (form)
            FORM_SHORT: send_byte({1'b1, len[6:0]});
            FORM_EXT16: begin
                send_byte({1'b1, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({1'b1, LEN_EXT64});
                for (i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
        endcase
        for (i = 3; i >= 0; i--)
            send_byte(key[8*i +: 8]);
    endtask

    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic [63:0] len, input int form,
                              input logic [31:0] key, input int fill);
        int j;
        send_header(fin, rsv, op, len, form, key);
        for (j = 0; j < len; j++) begin
            case (fill)
                FILL_ZERO: send_byte(8'h00);
                FILL_ONES: send_byte(8'hff);
                default:   send_byte($urandom_range(255, 0));
            endcase
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    function automatic int pick_form(input logic [63:0] len);
        int r;
        r = $urandom_range(7, 0);
        if (len < 126 && r < 5)
            return FORM_SHORT;
        if (len < 65536 && r < 7)
            return FORM_EXT16;
        return FORM_EXT64;
    endfunction

    function automatic logic [3:0] pick_data_op();
        logic [3:0] op;
        do
            op = $urandom_range(15, 1);
        while (op == OP_CLOSE);
        return op;
    endfunction

    initial begin
        int          frames;
        int          r;
        int          k;
        logic        fin;
        logic [2:0]  rsv;
        logic [3:0]  op;
        logic [63:0] len;
        t_ending     ending;

        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // zero-length, all header bits set, key all ones
        send_frame(1'b1, 3'b111, 4'hf, 64'd0, FORM_SHORT, 32'hffff_ffff, FILL_RANDOM);
        // fragment start, 16-bit length, zero key
        send_frame(1'b0, 3'b000, 4'h1, 64'd3, FORM_EXT16, 32'h0000_0000, FILL_ONES);
        // final continuation, 64-bit length, length byte 0xff
        send_frame(1'b1, 3'b000, OP_CONTINUE, 64'd1, FORM_EXT64, 32'ha5c3_0f96, FILL_ZERO);
        // header byte 0x00 opens a message with a continuation opcode
        send_frame(1'b0, 3'b000, OP_CONTINUE, 64'd0, FORM_SHORT, $urandom, FILL_RANDOM);
        // final control frame in the middle of a message
        send_frame(1'b1, 3'b010, 4'h9, 64'd2, FORM_SHORT, $urandom, FILL_RANDOM);
        send_frame(1'b1, 3'b000, OP_CONTINUE, 64'd65535 - 65500, FORM_EXT16, $urandom,
                   FILL_RANDOM);

        frames = 0;
        while (sent_bytes < RANDOM_BYTES - 40) begin
            gaps_on = !(frames >= 15 && frames < 40);
            if (frames == 8 || frames == 60)
                wait_drained();
            fin = ($urandom_range(2, 0) != 0);
            rsv = ($urandom_range(3, 0) == 0) ? 3'($urandom_range(7, 1)) : 3'b000;
            op  = ($urandom_range(9, 0) < 3) ? OP_CONTINUE : pick_data_op();
            r   = $urandom_range(19, 0);
            if (r < 3)
                len = 64'd0;
            else if (r < 17)
                len = $urandom_range(8, 1);
            else if (r < 19)
                len = $urandom_range(40, 9);
            else
                len = $urandom_range(300, 100);
            send_frame(fin, rsv, op, len, pick_form(len), $urandom, FILL_RANDOM);
            frames++;
        end
        gaps_on = 1'b1;

        ending = t_ending'($urandom_range(4, 0));
        case (ending)
            END_CLOSE: begin
                len = $urandom_range(6, 2);
                send_frame(1'b1, 3'b000, OP_CLOSE, len, pick_form(len), $urandom,
                           FILL_RANDOM);
            end
            END_CLOSE_SHORT: begin
                len = $urandom_range(1, 0);
                send_frame(1'b1, 3'b000, OP_CLOSE, len, pick_form(len), $urandom,
                           FILL_RANDOM);
            end
            END_CLOSE_FRAG: begin
                send_frame(1'b0, 3'b000, 4'h2, 64'd3, FORM_SHORT, $urandom, FILL_RANDOM);
                len = $urandom_range(4, 0);
                send_frame(1'b0, 3'b000, OP_CLOSE, len, pick_form(len), $urandom,
                           FILL_RANDOM);
            end
            END_UNMASKED: begin
                send_byte($urandom_range(255, 0));
                send_byte($urandom_range(127, 0));
            end
            default: begin
                // announced length far beyond what the run can deliver
                send_header(1'b1, 3'b000, pick_data_op(), {64{1'b1}}, FORM_EXT64,
                            $urandom);
                for (k = 0; k < 24; k++)
                    send_byte($urandom_range(255, 0));
            end
        endcase
        if (ending != END_HUGE) begin
            for (k = 0; k < 16; k++)
                send_byte($urandom_range(255, 0));
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
